// ===== sv/ssc_pkg.sv =====
// ----------------------------------------------------------------------------
// ssc_pkg: shared types and constants of the servo steering slew controller
// Word formats of the request and response channels, register map, command
// codes, controller states and the interface of the bit-serial divider.
// ----------------------------------------------------------------------------
package ssc_pkg;

   localparam int PULSE_W    = 12;
   localparam int POS_W      = 7;
   localparam int RATE_W     = 8;
   localparam int KIND_W     = 3;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;

   // Divider: numerator holds |diff| * 50 for a 12-bit diff or span * step, denominator a span or 50.
   localparam int DIV_NUM_W = 18;
   localparam int DIV_DEN_W = 12;
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

   localparam logic [POS_W-1:0] POS_MID = 7'd50;
   localparam logic [POS_W-1:0] POS_TOP = 7'd100;

   localparam logic [KIND_W-1:0] KIND_TICK    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_SET_POS = 3'd1;
   localparam logic [KIND_W-1:0] KIND_SET_RAW = 3'd2;
   localparam logic [KIND_W-1:0] KIND_ENABLE  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_DISABLE = 3'd4;

   localparam logic [REG_IDX_W-1:0] REG_LEFT    = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_CENTER  = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_RIGHT   = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_FLOOR   = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_CEILING = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_STEP    = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_DIVIDER = 3'd6;

   localparam logic [PULSE_W-1:0] LEFT_RESET    = 12'd2400;
   localparam logic [PULSE_W-1:0] CENTER_RESET  = 12'd1500;
   localparam logic [PULSE_W-1:0] RIGHT_RESET   = 12'd800;
   localparam logic [PULSE_W-1:0] FLOOR_RESET   = 12'd500;
   localparam logic [PULSE_W-1:0] CEILING_RESET = 12'd2500;
   localparam logic [RATE_W-1:0]  STEP_RESET    = 8'd8;
   localparam logic [RATE_W-1:0]  DIVIDER_RESET = 8'd2;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [7:0]        position;
      logic [15:0]       raw_pulse;
   } req_type;

   typedef struct packed {
      logic [PULSE_W-1:0] current_pulse;
      logic [PULSE_W-1:0] target_pulse;
      logic [POS_W-1:0]   current_position;
      logic [POS_W-1:0]   target_position;
      logic               moving;
      logic               active;
   } rsp_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] numer;
      logic [DIV_DEN_W-1:0] denom;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_NUM_W-1:0] quot;
   } div_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POS_START,
      ST_POS_WAIT,
      ST_INV_START,
      ST_INV_WAIT,
      ST_HOLD
   } state_type;

endpackage

// ===== sv/servo_steering_slew_controller_top.sv =====
// ----------------------------------------------------------------------------
// servo_steering_slew_controller_top: slew-limited servo pulse controller
// Maps positions to pulse widths through three calibration points, slews the
// driven pulse toward the target and reports both pulses mapped back to 0..100.
// ----------------------------------------------------------------------------
// Usage: each request word carries a command (tick, set position, set raw
// pulse, enable, disable) and yields exactly one response word with the
// current and target pulse, their positions and the moving and active flags.
// Calibration, clamp and slew settings sit in the APB-style register file;
// the user must write them only while the block is idle, which the block
// itself does not enforce. Reads return the stored values.
// The block takes one word at a time and accepts no new word until the
// response to the last one is in the output register. For a set-position
// word other than the center position, one bit-serial divider pass maps the
// position to a pulse; every word then takes a pass that maps both pulses
// back to positions on two dividers side by side.
// The response sits in an output register, so the next request is accepted
// while a response still waits; a stalled response holds its word, and a
// finished word then waits in the controller until the register frees up.
// Reset restores the register defaults, disables slewing, puts both pulses at
// 1500 and clears the tick count; no response is pending after reset.
// ----------------------------------------------------------------------------
module servo_steering_slew_controller_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  ssc_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output ssc_pkg::rsp_type                  rsp_data,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [ssc_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [ssc_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [ssc_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   typedef struct packed {
      logic                      fixed;
      logic [ssc_pkg::POS_W-1:0] fixed_pos;
      logic                      add;
   } inv_info_type;

   typedef struct packed {
      logic [ssc_pkg::DIV_NUM_W-1:0] numer;
      logic [ssc_pkg::DIV_DEN_W-1:0] denom;
      inv_info_type                  info;
   } inv_setup_type;

   function automatic logic [ssc_pkg::PULSE_W-1:0] clamp_pulse(
      input logic [15:0]                  p,
      input logic [ssc_pkg::PULSE_W-1:0]  lo,
      input logic [ssc_pkg::PULSE_W-1:0]  hi);
      logic [ssc_pkg::PULSE_W-1:0] r;
      if (p < {4'd0, lo}) begin
         r = lo;
      end else if (p > {4'd0, hi}) begin
         r = hi;
      end else begin
         r = p[ssc_pkg::PULSE_W-1:0];
      end
      return r;
   endfunction

   // Sets up the inverse map of one pulse: either a fixed answer or a division
   // of |diff| * 50 by |span| whose quotient is added to or taken from 50.
   function automatic inv_setup_type inv_setup(
      input logic [ssc_pkg::PULSE_W-1:0] pulse,
      input logic [ssc_pkg::PULSE_W-1:0] l,
      input logic [ssc_pkg::PULSE_W-1:0] c,
      input logic [ssc_pkg::PULSE_W-1:0] r);
      inv_setup_type         s;
      logic [12:0]           diff;
      logic [12:0]           span;
      logic [12:0]           dmag;
      logic [12:0]           smag;
      logic                  left_side;
      logic                  neg;
      s         = '0;
      diff      = {1'b0, pulse} - {1'b0, c};
      left_side = (!diff[12]) == (l > c);
      span      = left_side ? ({1'b0, l} - {1'b0, c}) : ({1'b0, r} - {1'b0, c});
      dmag      = diff[12] ? (13'd0 - diff) : diff;
      smag      = span[12] ? (13'd0 - span) : span;
      neg       = diff[12] ^ span[12];
      if (diff == '0) begin
         s.info.fixed     = 1'b1;
         s.info.fixed_pos = ssc_pkg::POS_MID;
      end else if (span == '0) begin
         s.info.fixed     = 1'b1;
         s.info.fixed_pos = left_side ? '0 : ssc_pkg::POS_TOP;
      end else begin
         s.numer    = {6'd0, dmag[11:0]} * {11'd0, ssc_pkg::POS_MID};
         s.denom    = smag[11:0];
         s.info.add = left_side ? neg : !neg;
      end
      return s;
   endfunction

   function automatic logic [ssc_pkg::POS_W-1:0] inv_finish(
      input logic [ssc_pkg::DIV_NUM_W-1:0] q,
      input inv_info_type                  info);
      logic [ssc_pkg::POS_W-1:0] p;
      logic                      big;
      big = q >= {11'd0, ssc_pkg::POS_MID};
      if (info.fixed) begin
         p = info.fixed_pos;
      end else if (info.add) begin
         p = big ? ssc_pkg::POS_TOP : ssc_pkg::POS_MID + q[ssc_pkg::POS_W-1:0];
      end else begin
         p = big ? '0 : ssc_pkg::POS_MID - q[ssc_pkg::POS_W-1:0];
      end
      return p;
   endfunction

   // Register file.
   logic [ssc_pkg::PULSE_W-1:0] left_ff, left_in;
   logic [ssc_pkg::PULSE_W-1:0] center_ff, center_in;
   logic [ssc_pkg::PULSE_W-1:0] right_ff, right_in;
   logic [ssc_pkg::PULSE_W-1:0] floor_ff, floor_in;
   logic [ssc_pkg::PULSE_W-1:0] ceiling_ff, ceiling_in;
   logic [ssc_pkg::RATE_W-1:0]  step_ff, step_in;
   logic [ssc_pkg::RATE_W-1:0]  divider_ff, divider_in;
   logic [ssc_pkg::REG_IDX_W-1:0] csr_index;
   logic                          csr_write;

   // Controller state.
   ssc_pkg::state_type          state_ff, state_in;
   logic                        enabled_ff, enabled_in;
   logic [ssc_pkg::PULSE_W-1:0] present_ff, present_in;
   logic [ssc_pkg::PULSE_W-1:0] goal_ff, goal_in;
   logic [ssc_pkg::RATE_W-1:0]  tick_ff, tick_in;

   // Forward map operands.
   logic [ssc_pkg::PULSE_W-1:0] map_from_ff, map_from_in;
   logic [ssc_pkg::PULSE_W-1:0] map_mag_ff, map_mag_in;
   logic                        map_neg_ff, map_neg_in;
   logic [5:0]                  map_step_ff, map_step_in;

   // Inverse map bookkeeping and results.
   inv_info_type                cur_info_ff, cur_info_in;
   inv_info_type                tgt_info_ff, tgt_info_in;
   logic [ssc_pkg::POS_W-1:0]   cur_pos_ff, cur_pos_in;
   logic [ssc_pkg::POS_W-1:0]   tgt_pos_ff, tgt_pos_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   ssc_pkg::rsp_type            rsp_data_ff, rsp_data_in;

   ssc_pkg::div_req_type        div0_req, div1_req;
   ssc_pkg::div_rsp_type        div0_rsp, div1_rsp;

   logic                        accept;
   logic                        out_load;
   logic [ssc_pkg::POS_W-1:0]   pos_clamp;
   logic                        map_low;
   logic                        map_mid;
   logic [ssc_pkg::PULSE_W-1:0] map_to;
   logic [12:0]                 map_delta;
   logic [12:0]                 map_delta_neg;
   logic [ssc_pkg::DIV_NUM_W-1:0] map_product;
   logic [ssc_pkg::PULSE_W-1:0] map_sum;
   logic [ssc_pkg::RATE_W-1:0]  tick_next;
   logic                        slew_due;
   logic [ssc_pkg::PULSE_W-1:0] gap;
   logic [ssc_pkg::PULSE_W-1:0] slew_pulse;
   inv_setup_type               cur_setup;
   inv_setup_type               tgt_setup;

   // ------------------------------------------------------------------ CSR
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[ssc_pkg::CSR_ADDR_W-1:2];

   always_comb begin
      left_in    = left_ff;
      center_in  = center_ff;
      right_in   = right_ff;
      floor_in   = floor_ff;
      ceiling_in = ceiling_ff;
      step_in    = step_ff;
      divider_in = divider_ff;
      if (csr_write) begin
         case (csr_index)
            ssc_pkg::REG_LEFT:    left_in    = csr_pwdata[ssc_pkg::PULSE_W-1:0];
            ssc_pkg::REG_CENTER:  center_in  = csr_pwdata[ssc_pkg::PULSE_W-1:0];
            ssc_pkg::REG_RIGHT:   right_in   = csr_pwdata[ssc_pkg::PULSE_W-1:0];
            ssc_pkg::REG_FLOOR:   floor_in   = csr_pwdata[ssc_pkg::PULSE_W-1:0];
            ssc_pkg::REG_CEILING: ceiling_in = csr_pwdata[ssc_pkg::PULSE_W-1:0];
            ssc_pkg::REG_STEP:    step_in    = csr_pwdata[ssc_pkg::RATE_W-1:0];
            ssc_pkg::REG_DIVIDER: divider_in = csr_pwdata[ssc_pkg::RATE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         ssc_pkg::REG_LEFT:    csr_prdata = {20'd0, left_ff};
         ssc_pkg::REG_CENTER:  csr_prdata = {20'd0, center_ff};
         ssc_pkg::REG_RIGHT:   csr_prdata = {20'd0, right_ff};
         ssc_pkg::REG_FLOOR:   csr_prdata = {20'd0, floor_ff};
         ssc_pkg::REG_CEILING: csr_prdata = {20'd0, ceiling_ff};
         ssc_pkg::REG_STEP:    csr_prdata = {24'd0, step_ff};
         ssc_pkg::REG_DIVIDER: csr_prdata = {24'd0, divider_ff};
         default:              csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------ datapath
   assign accept = req_valid && !req_stall;

   assign pos_clamp = (req_data.position > {1'b0, ssc_pkg::POS_TOP})
                      ? ssc_pkg::POS_TOP : req_data.position[ssc_pkg::POS_W-1:0];
   assign map_low   = pos_clamp < ssc_pkg::POS_MID;
   assign map_mid   = pos_clamp == ssc_pkg::POS_MID;
   assign map_from_in = map_low ? left_ff : center_ff;
   assign map_to      = map_low ? center_ff : right_ff;
   assign map_step_in = map_low ? pos_clamp[5:0] : 6'(pos_clamp - ssc_pkg::POS_MID);
   assign map_delta     = {1'b0, map_to} - {1'b0, map_from_in};
   assign map_delta_neg = 13'd0 - map_delta;
   assign map_neg_in    = map_delta[12];
   assign map_mag_in    = map_delta[12] ? map_delta_neg[11:0] : map_delta[11:0];

   assign map_product = {6'd0, map_mag_ff} * {12'd0, map_step_ff};
   // The quotient never exceeds the span, so the sum stays between the two ends.
   assign map_sum = map_neg_ff ? map_from_ff - div0_rsp.quot[ssc_pkg::PULSE_W-1:0]
                               : map_from_ff + div0_rsp.quot[ssc_pkg::PULSE_W-1:0];

   assign tick_next = tick_ff + 1'b1;
   assign slew_due  = tick_next >= divider_ff;
   assign gap       = (present_ff < goal_ff) ? goal_ff - present_ff : present_ff - goal_ff;

   always_comb begin
      if (gap <= {4'd0, step_ff}) begin
         slew_pulse = goal_ff;
      end else if (present_ff < goal_ff) begin
         slew_pulse = present_ff + {4'd0, step_ff};
      end else begin
         slew_pulse = present_ff - {4'd0, step_ff};
      end
   end

   always_comb begin
      enabled_in = enabled_ff;
      present_in = present_ff;
      goal_in    = goal_ff;
      tick_in    = tick_ff;
      if (accept) begin
         case (req_data.kind)
            ssc_pkg::KIND_TICK: begin
               if (!enabled_ff) begin
                  tick_in = '0;
               end else if (slew_due) begin
                  tick_in    = '0;
                  present_in = slew_pulse;
               end else begin
                  tick_in = tick_next;
               end
            end
            ssc_pkg::KIND_SET_POS: begin
               if (map_mid) begin
                  goal_in = center_ff;
               end
            end
            ssc_pkg::KIND_SET_RAW: begin
               goal_in = clamp_pulse(req_data.raw_pulse, floor_ff, ceiling_ff);
            end
            ssc_pkg::KIND_ENABLE: begin
               enabled_in = 1'b1;
            end
            ssc_pkg::KIND_DISABLE: begin
               enabled_in = 1'b0;
               present_in = center_ff;
               goal_in    = center_ff;
               tick_in    = '0;
            end
            default: ;
         endcase
      end
      if (state_ff == ssc_pkg::ST_POS_WAIT && div0_rsp.done) begin
         goal_in = clamp_pulse({4'd0, map_sum}, floor_ff, ceiling_ff);
      end
   end

   assign cur_setup = inv_setup(present_ff, left_ff, center_ff, right_ff);
   assign tgt_setup = inv_setup(goal_ff, left_ff, center_ff, right_ff);

   always_comb begin
      cur_info_in = cur_info_ff;
      tgt_info_in = tgt_info_ff;
      cur_pos_in  = cur_pos_ff;
      tgt_pos_in  = tgt_pos_ff;
      if (state_ff == ssc_pkg::ST_INV_START) begin
         cur_info_in = cur_setup.info;
         tgt_info_in = tgt_setup.info;
      end
      if (state_ff == ssc_pkg::ST_INV_WAIT && div0_rsp.done) begin
         cur_pos_in = inv_finish(div0_rsp.quot, cur_info_ff);
         tgt_pos_in = inv_finish(div1_rsp.quot, tgt_info_ff);
      end
   end

   always_comb begin
      rsp_data_in                  = rsp_data_ff;
      rsp_valid_in                 = rsp_valid_ff && rsp_stall;
      if (out_load) begin
         rsp_valid_in                  = 1'b1;
         rsp_data_in.current_pulse    = present_ff;
         rsp_data_in.target_pulse     = goal_ff;
         rsp_data_in.current_position = cur_pos_ff;
         rsp_data_in.target_position  = tgt_pos_ff;
         rsp_data_in.moving           = present_ff != goal_ff;
         rsp_data_in.active           = enabled_ff;
      end
   end

   // ------------------------------------------------------------ sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ssc_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_data.kind == ssc_pkg::KIND_SET_POS && !map_mid) begin
                  state_in = ssc_pkg::ST_POS_START;
               end else begin
                  state_in = ssc_pkg::ST_INV_START;
               end
            end
         end
         ssc_pkg::ST_POS_START: state_in = ssc_pkg::ST_POS_WAIT;
         ssc_pkg::ST_POS_WAIT: begin
            if (div0_rsp.done) begin
               state_in = ssc_pkg::ST_INV_START;
            end
         end
         ssc_pkg::ST_INV_START: state_in = ssc_pkg::ST_INV_WAIT;
         ssc_pkg::ST_INV_WAIT: begin
            if (div0_rsp.done) begin
               state_in = ssc_pkg::ST_HOLD;
            end
         end
         ssc_pkg::ST_HOLD: begin
            if (out_load) begin
               state_in = ssc_pkg::ST_IDLE;
            end
         end
         default: state_in = ssc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = state_ff != ssc_pkg::ST_IDLE;
      out_load  = state_ff == ssc_pkg::ST_HOLD && (!rsp_valid_ff || !rsp_stall);
      div0_req  = '0;
      div1_req  = '0;
      case (state_ff)
         ssc_pkg::ST_POS_START: begin
            div0_req.start = 1'b1;
            div0_req.numer = map_product;
            div0_req.denom = ssc_pkg::DIV_DEN_W'(ssc_pkg::POS_MID);
         end
         ssc_pkg::ST_INV_START: begin
            div0_req.start = 1'b1;
            div0_req.numer = cur_setup.numer;
            div0_req.denom = cur_setup.denom;
            div1_req.start = 1'b1;
            div1_req.numer = tgt_setup.numer;
            div1_req.denom = tgt_setup.denom;
         end
         default: ;
      endcase
   end

   ssc_serial_div u_div_cur (
      .clock   (clock),
      .reset   (reset),
      .div_req (div0_req),
      .div_rsp (div0_rsp)
   );

   ssc_serial_div u_div_tgt (
      .clock   (clock),
      .reset   (reset),
      .div_req (div1_req),
      .div_rsp (div1_rsp)
   );

   // ------------------------------------------------------------ registers
   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff      <= ssc_pkg::LEFT_RESET;
         center_ff    <= ssc_pkg::CENTER_RESET;
         right_ff     <= ssc_pkg::RIGHT_RESET;
         floor_ff     <= ssc_pkg::FLOOR_RESET;
         ceiling_ff   <= ssc_pkg::CEILING_RESET;
         step_ff      <= ssc_pkg::STEP_RESET;
         divider_ff   <= ssc_pkg::DIVIDER_RESET;
         state_ff     <= ssc_pkg::ST_IDLE;
         enabled_ff   <= 1'b0;
         present_ff   <= ssc_pkg::CENTER_RESET;
         goal_ff      <= ssc_pkg::CENTER_RESET;
         tick_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         left_ff      <= left_in;
         center_ff    <= center_in;
         right_ff     <= right_in;
         floor_ff     <= floor_in;
         ceiling_ff   <= ceiling_in;
         step_ff      <= step_in;
         divider_ff   <= divider_in;
         state_ff     <= state_in;
         enabled_ff   <= enabled_in;
         present_ff   <= present_in;
         goal_ff      <= goal_in;
         tick_ff      <= tick_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         map_from_ff <= map_from_in;
         map_mag_ff  <= map_mag_in;
         map_neg_ff  <= map_neg_in;
         map_step_ff <= map_step_in;
      end
      cur_info_ff <= cur_info_in;
      tgt_info_ff <= tgt_info_in;
      cur_pos_ff  <= cur_pos_in;
      tgt_pos_ff  <= tgt_pos_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== sv/ssc_serial_div.sv =====
// ----------------------------------------------------------------------------
// ssc_serial_div: bit-serial restoring divider
// Produces one quotient bit per cycle, most significant first. The done flag
// rises together with the final quotient.
// ----------------------------------------------------------------------------
module ssc_serial_div (
   input  logic                clock,
   input  logic                reset,
   input  ssc_pkg::div_req_type div_req,
   output ssc_pkg::div_rsp_type div_rsp
);

   logic [ssc_pkg::DIV_CNT_W-1:0] count_ff, count_in;
   logic                          done_ff, done_in;
   logic [ssc_pkg::DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [ssc_pkg::DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [ssc_pkg::DIV_DEN_W-1:0] den_ff, den_in;
   logic [ssc_pkg::DIV_DEN_W:0]   shifted;
   logic [ssc_pkg::DIV_DEN_W:0]   trial;
   logic                          fits;

   // The partial remainder stays below the divisor, so it fits the divisor width.
   assign shifted = {rem_ff, quo_ff[ssc_pkg::DIV_NUM_W-1]};
   assign fits    = shifted >= {1'b0, den_ff};
   assign trial   = shifted - {1'b0, den_ff};

   always_comb begin
      count_in = count_ff;
      done_in  = 1'b0;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      den_in   = den_ff;
      if (div_req.start) begin
         count_in = ssc_pkg::DIV_CNT_W'(ssc_pkg::DIV_NUM_W);
         rem_in   = '0;
         quo_in   = div_req.numer;
         den_in   = div_req.denom;
      end else if (count_ff != '0) begin
         count_in = count_ff - 1'b1;
         done_in  = count_ff == ssc_pkg::DIV_CNT_W'(1);
         rem_in   = fits ? trial[ssc_pkg::DIV_DEN_W-1:0]
                         : shifted[ssc_pkg::DIV_DEN_W-1:0];
         quo_in   = {quo_ff[ssc_pkg::DIV_NUM_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quo_ff;

endmodule

// ===== sv/ssc_checker.sv =====
// ----------------------------------------------------------------------------
// ssc_checker: port-level checks of the servo steering slew controller
// Watches the request and response channels and is bound to the top level.
// ----------------------------------------------------------------------------
module ssc_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input ssc_pkg::rsp_type rsp_data
);

   // A stalled response word must stay put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response word changed while stalled");

   // The controller works on one word at a time.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while a word was still in progress");

   a_moving_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.moving ==
                    (rsp_data.current_pulse != rsp_data.target_pulse))
      else $error("moving flag disagrees with the reported pulses");

   a_position_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.current_position <= ssc_pkg::POS_TOP &&
                    rsp_data.target_position <= ssc_pkg::POS_TOP)
      else $error("reported position out of range");

   // Equal pulses go through the same inverse map and must agree.
   a_same_pulse_same_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.current_pulse == rsp_data.target_pulse |->
         rsp_data.current_position == rsp_data.target_position)
      else $error("equal pulses mapped to different positions");

endmodule

bind servo_steering_slew_controller_top ssc_checker u_ssc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
